FILE: rtl/csrmv_pkg.sv
// shared types and constants for the csr sparse matrix-vector update block
package csrmv_pkg;

    localparam int VECTOR_DEPTH_DEF = 4096;
    localparam int INDEX_W          = 12;
    localparam int DATA_W           = 32;
    localparam int ACC_W            = 64;
    localparam int PADDR_W          = 3;

    localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;
    localparam logic              REG_SCALE   = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_NZ    = 2'd1,
        OP_EMPTY = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN_LO,
        ST_FIN_HI,
        ST_FIN_ADD,
        ST_FIN_OUT
    } t_state;

endpackage

FILE: rtl/csr_sparse_matrix_vector_update.sv
// top level of the csr sparse matrix-vector update block, y = a*A*x + y
// load item: written to the vector ram if the index is in range; empty-row item: result registered next cycle
// nonzero item: vector ram read, then 32x32 multiply; input stalls until the multiply step ends
// row end: after the closing item's multiply: accumulate, two halves of the scale multiply
// on one shared 25x32 multiplier, wide add and clamp, add y and saturate (held while output stalls)
// reset clears control, accumulator and output valid; scale returns to 1.0; vector ram is not cleared
module csr_sparse_matrix_vector_update #(
    parameter int VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_opcode,
    input  logic [csrmv_pkg::INDEX_W-1:0]       i_index,
    input  logic signed [csrmv_pkg::DATA_W-1:0] i_value,
    input  logic                                i_row_last,
    input  logic signed [csrmv_pkg::DATA_W-1:0] i_y_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [csrmv_pkg::DATA_W-1:0] o_y_out,
    output logic                                o_saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csrmv_pkg::PADDR_W-1:0]       paddr,
    input  logic [csrmv_pkg::DATA_W-1:0]        pwdata,
    output logic [csrmv_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int AW = $clog2(VECTOR_DEPTH);
    localparam int IW = csrmv_pkg::INDEX_W;
    localparam int XW = AW + IW;

    csrmv_pkg::t_state  r_state, n_state;
    csrmv_pkg::t_opcode op;

    logic signed [31:0] r_scale;
    logic signed [63:0] r_sum, n_sum;
    logic signed [47:0] r_prod;
    logic               r_prod_vld, n_prod_vld;
    logic signed [31:0] r_value, r_y;
    logic               r_last, r_idx_ok;
    logic [56:0]        r_mlo, r_mhi;
    logic [33:0]        r_m;
    logic               r_out_vld;
    logic signed [31:0] r_y_out, n_y_out;
    logic               r_sat, n_sat;
    logic               out_load;

    logic               in_acc, out_free, cfg_wr;
    logic [XW-1:0]      idx_ext;
    logic               idx_ok;
    logic [31:0]        rd_data;
    logic signed [31:0] x_sel;
    logic signed [63:0] prod_full;

    logic signed [63:0] addend, acc_sum, acc_sat;
    logic               acc_ovf;

    logic [63:0]        sum_mag;
    logic [48:0]        ms;
    logic [31:0]        ma;
    logic [24:0]        mul_a;
    logic [56:0]        mul_p;
    logic [80:0]        full;
    logic [64:0]        m_full;
    logic [33:0]        m_clamp;
    logic               neg;
    logic signed [35:0] m_s, prod_s, tot;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = (r_state != csrmv_pkg::ST_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign op         = csrmv_pkg::t_opcode'(i_opcode);

    assign idx_ext = {{AW{1'b0}}, i_index};
    assign idx_ok  = idx_ext < XW'(VECTOR_DEPTH);

    csrmv_ram #(
        .WIDTH (csrmv_pkg::DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && op == csrmv_pkg::OP_LOAD && idx_ok),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (in_acc && op == csrmv_pkg::OP_NZ),
        .i_raddr (idx_ext[AW-1:0]),
        .o_rdata (rd_data)
    );

    // product of the nonzero and the vector element (zero when the index is out of range)
    assign x_sel     = r_idx_ok ? signed'(rd_data) : 32'sd0;
    assign prod_full = r_value * x_sel;

    // saturating accumulate of the pending product
    assign addend  = {{16{r_prod[47]}}, r_prod};
    assign acc_sum = r_sum + addend;
    assign acc_ovf = (r_sum[63] == addend[63]) && (acc_sum[63] != r_sum[63]);
    assign acc_sat = acc_ovf ? (r_sum[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc_sum;

    // row end: |sum| clamped to 2^48 times |scale|, split in two halves
    assign sum_mag = r_sum[63] ? (64'd0 - r_sum) : r_sum;
    assign ms      = (sum_mag > 64'h0001_0000_0000_0000) ? {1'b1, 48'd0} : sum_mag[48:0];
    assign ma      = r_scale[31] ? (32'd0 - r_scale) : r_scale;
    assign mul_a   = (r_state == csrmv_pkg::ST_FIN_LO) ? {1'b0, ms[23:0]} : ms[48:24];
    assign mul_p   = mul_a * ma;

    assign full    = {r_mhi, 24'd0} + {24'd0, r_mlo};
    assign m_full  = full[80:16];
    assign m_clamp = (m_full > 65'h2_0000_0000) ? 34'h2_0000_0000 : m_full[33:0];

    assign neg    = r_sum[63] ^ r_scale[31];
    assign m_s    = {2'b00, r_m};
    assign prod_s = neg ? -m_s : m_s;
    assign tot    = prod_s + {{4{r_y[31]}}, r_y};

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_prod_vld = r_prod_vld;
        out_load   = 1'b0;
        n_y_out    = r_y_out;
        n_sat      = r_sat;
        if (r_prod_vld) begin
            n_sum      = acc_sat;
            n_prod_vld = 1'b0;
        end
        case (r_state)
            csrmv_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (op)
                        csrmv_pkg::OP_NZ: begin
                            n_state = csrmv_pkg::ST_MUL;
                        end
                        csrmv_pkg::OP_EMPTY: begin
                            n_sum    = 64'sd0;
                            out_load = 1'b1;
                            n_y_out  = i_y_in;
                            n_sat    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            csrmv_pkg::ST_MUL: begin
                n_prod_vld = 1'b1;
                n_state    = r_last ? csrmv_pkg::ST_ACC : csrmv_pkg::ST_IDLE;
            end
            csrmv_pkg::ST_ACC: begin
                n_state = csrmv_pkg::ST_FIN_LO;
            end
            csrmv_pkg::ST_FIN_LO: begin
                n_state = csrmv_pkg::ST_FIN_HI;
            end
            csrmv_pkg::ST_FIN_HI: begin
                n_state = csrmv_pkg::ST_FIN_ADD;
            end
            csrmv_pkg::ST_FIN_ADD: begin
                n_state = csrmv_pkg::ST_FIN_OUT;
            end
            csrmv_pkg::ST_FIN_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_sum    = 64'sd0;
                    n_state  = csrmv_pkg::ST_IDLE;
                    if (tot > 36'sh0_7FFF_FFFF) begin
                        n_y_out = 32'sh7FFF_FFFF;
                        n_sat   = 1'b1;
                    end else if (tot < 36'shF_8000_0000) begin
                        n_y_out = 32'sh8000_0000;
                        n_sat   = 1'b1;
                    end else begin
                        n_y_out = tot[31:0];
                        n_sat   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = csrmv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= csrmv_pkg::ST_IDLE;
            r_sum      <= 64'sd0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_scale    <= csrmv_pkg::SCALE_RESET;
        end else begin
            r_state    <= n_state;
            r_sum      <= n_sum;
            r_prod_vld <= n_prod_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (cfg_wr) begin
                r_scale <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_value  <= i_value;
            r_last   <= i_row_last;
            r_y      <= i_y_in;
            r_idx_ok <= idx_ok;
        end
        if (r_state == csrmv_pkg::ST_MUL) begin
            r_prod <= prod_full[63:16];
        end
        if (r_state == csrmv_pkg::ST_FIN_LO) begin
            r_mlo <= mul_p;
        end
        if (r_state == csrmv_pkg::ST_FIN_HI) begin
            r_mhi <= mul_p;
        end
        if (r_state == csrmv_pkg::ST_FIN_ADD) begin
            r_m <= m_clamp;
        end
        if (out_load) begin
            r_y_out <= n_y_out;
            r_sat   <= n_sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_y_out     = r_y_out;
    assign o_saturated = r_sat;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == csrmv_pkg::REG_SCALE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == csrmv_pkg::REG_SCALE) ? r_scale : 32'd0;

    a_nz_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && op == csrmv_pkg::OP_NZ) |=> (r_state == csrmv_pkg::ST_MUL))
        else $error("nonzero item did not enter the multiply step");

    a_acc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csrmv_pkg::ST_FIN_LO) |-> !r_prod_vld)
        else $error("row end started with a product still pending");

    a_sat_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_y_out == 32'sh7FFF_FFFF || o_y_out == 32'sh8000_0000))
        else $error("saturated result is not at a range limit");

endmodule

FILE: rtl/csrmv_ram.sv
// generic single-write single-read ram with registered read data
module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
